FILE: hdl/gpc_pkg.sv
// gpc_pkg: shared types, codes and constants of the gpio pin config controller
// no dependencies; used by every module in hdl/ but gpc_queue
`default_nettype none

package gpc_pkg;

	// request kinds
	typedef enum logic [2:0] {
		KIND_SET_FUNC   = 3'd0,
		KIND_GET_FUNC   = 3'd1,
		KIND_WRITE_BIT  = 3'd2,
		KIND_READ_BIT   = 3'd3,
		KIND_SET_PULLUP = 3'd4
	} kind_t;

	// group codes carried in pin_id[11:8]
	localparam logic [3:0] GROUP_B = 4'd0;
	localparam logic [3:0] GROUP_C = 4'd1;
	localparam logic [3:0] GROUP_D = 4'd2;
	localparam logic [3:0] GROUP_E = 4'd3;
	localparam logic [3:0] GROUP_F = 4'd4;
	localparam logic [3:0] GROUP_G = 4'd5;

	// default last pin of each group
	localparam int LAST_PIN_B_DEF = 12;
	localparam int LAST_PIN_C_DEF = 7;
	localparam int LAST_PIN_D_DEF = 22;
	localparam int LAST_PIN_E_DEF = 17;
	localparam int LAST_PIN_F_DEF = 6;
	localparam int LAST_PIN_G_DEF = 18;

	// storage geometry
	localparam int NUM_GROUPS = 6;
	localparam int GROUP_W    = 3;
	localparam int IDX_W      = 5;
	localparam int FUNC_W     = 4;
	localparam int WORD_W     = 32;
	localparam int FUNC_WORDS = 18;
	localparam int DATA_WORDS = 6;
	localparam int PULL_WORDS = 12;
	localparam int FW_IDX_W   = 5;
	localparam int PW_IDX_W   = 4;

	localparam logic [1:0] PULL_UP = 2'b01;

	// default queue depths
	localparam int CMD_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF = 2;

	// classified request handed from front to back
	typedef struct packed {
		kind_t               kind;
		logic [GROUP_W-1:0]  group;
		logic [IDX_W-1:0]    idx;
		logic [FUNC_W-1:0]   func;
		logic                level;
		logic                bad;
	} cmd_t;

	// finished result
	typedef struct packed {
		logic [FUNC_W-1:0] read_value;
		logic              invalid;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/gpc_queue.sv
// gpc_queue: small first-in first-out queue with full/empty flags
// no package dependencies; used for the command and result queues
`default_nettype none

module gpc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/gpc_front.sv
// gpc_front: decodes a request and checks pin, kind and function code
// depends on gpc_pkg
`default_nettype none

module gpc_front #(
	parameter int LAST_PIN_B = gpc_pkg::LAST_PIN_B_DEF,
	parameter int LAST_PIN_C = gpc_pkg::LAST_PIN_C_DEF,
	parameter int LAST_PIN_D = gpc_pkg::LAST_PIN_D_DEF,
	parameter int LAST_PIN_E = gpc_pkg::LAST_PIN_E_DEF,
	parameter int LAST_PIN_F = gpc_pkg::LAST_PIN_F_DEF,
	parameter int LAST_PIN_G = gpc_pkg::LAST_PIN_G_DEF
) (
	input  wire logic [2:0]  kind,
	input  wire logic [11:0] pin_id,
	input  wire logic [7:0]  value,
	output gpc_pkg::cmd_t    cmd
);

	logic [gpc_pkg::IDX_W-1:0] last_pin;
	logic                      group_ok;
	logic                      pin_ok;
	logic                      kind_ok;
	logic                      func_ok;

	// last pin of the addressed group
	always_comb begin
		group_ok = 1'b1;
		case (pin_id[11:8])
			gpc_pkg::GROUP_B: last_pin = gpc_pkg::IDX_W'(LAST_PIN_B);
			gpc_pkg::GROUP_C: last_pin = gpc_pkg::IDX_W'(LAST_PIN_C);
			gpc_pkg::GROUP_D: last_pin = gpc_pkg::IDX_W'(LAST_PIN_D);
			gpc_pkg::GROUP_E: last_pin = gpc_pkg::IDX_W'(LAST_PIN_E);
			gpc_pkg::GROUP_F: last_pin = gpc_pkg::IDX_W'(LAST_PIN_F);
			gpc_pkg::GROUP_G: last_pin = gpc_pkg::IDX_W'(LAST_PIN_G);
			default: begin
				last_pin = '0;
				group_ok = 1'b0;
			end
		endcase
	end

	// index must sit within the addressed group
	assign pin_ok = group_ok && (pin_id[7:0] <= {3'b000, last_pin});

	// kind and function code checks
	assign kind_ok = kind inside {gpc_pkg::KIND_SET_FUNC, gpc_pkg::KIND_GET_FUNC,
		gpc_pkg::KIND_WRITE_BIT, gpc_pkg::KIND_READ_BIT, gpc_pkg::KIND_SET_PULLUP};
	assign func_ok = (gpc_pkg::kind_t'(kind) != gpc_pkg::KIND_SET_FUNC) ||
		(value[7:4] == 4'd0);

	// classified command
	always_comb begin
		cmd.kind  = gpc_pkg::kind_t'(kind);
		cmd.group = pin_id[10:8];
		cmd.idx   = pin_id[gpc_pkg::IDX_W-1:0];
		cmd.func  = value[gpc_pkg::FUNC_W-1:0];
		cmd.level = (value != 8'd0);
		cmd.bad   = !(kind_ok && pin_ok && func_ok);
	end

endmodule

`default_nettype wire

FILE: hdl/gpc_back.sv
// gpc_back: holds the function, data and pull stores and carries out commands
// depends on gpc_pkg
`default_nettype none

module gpc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gpc_pkg::cmd_t cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_pop,
	input  wire logic          res_full,
	output logic               res_push,
	output gpc_pkg::res_t      res
);

	logic [gpc_pkg::WORD_W-1:0]   func_words_q [gpc_pkg::FUNC_WORDS];
	logic [gpc_pkg::WORD_W-1:0]   data_words_q [gpc_pkg::DATA_WORDS];
	logic [gpc_pkg::WORD_W-1:0]   pull_words_q [gpc_pkg::PULL_WORDS];

	logic [gpc_pkg::FW_IDX_W-1:0] fw;
	logic [gpc_pkg::PW_IDX_W-1:0] pw;
	logic [gpc_pkg::WORD_W-1:0]   func_rd;
	logic [gpc_pkg::WORD_W-1:0]   data_rd;
	logic [gpc_pkg::WORD_W-1:0]   pull_rd;
	logic [gpc_pkg::WORD_W-1:0]   func_new;
	logic [gpc_pkg::WORD_W-1:0]   data_new;
	logic [gpc_pkg::WORD_W-1:0]   pull_new;
	logic                         go;
	logic                         func_we;
	logic                         data_we;
	logic                         pull_we;

	// one command per cycle while a result slot is free
	assign go       = cmd_valid && !res_full;
	assign cmd_pop  = go;
	assign res_push = go;

	// word addresses: group*3 + idx/8 and group*2 + idx/16
	assign fw = gpc_pkg::FW_IDX_W'(cmd.group) * gpc_pkg::FW_IDX_W'(3)
		+ gpc_pkg::FW_IDX_W'(cmd.idx[4:3]);
	assign pw = {cmd.group, cmd.idx[4]};

	assign func_rd = func_words_q[fw];
	assign data_rd = data_words_q[cmd.group];
	assign pull_rd = pull_words_q[pw];

	// field inserts
	always_comb begin
		func_new = func_rd;
		func_new[{cmd.idx[2:0], 2'b00} +: gpc_pkg::FUNC_W] = cmd.func;
		data_new = data_rd;
		data_new[cmd.idx] = cmd.level;
		pull_new = pull_rd;
		pull_new[{cmd.idx[3:0], 1'b0} +: 2] = gpc_pkg::PULL_UP;
	end

	// write enables and result
	always_comb begin
		func_we        = 1'b0;
		data_we        = 1'b0;
		pull_we        = 1'b0;
		res.read_value = '0;
		res.invalid    = cmd.bad;
		if (!cmd.bad) begin
			case (cmd.kind)
				gpc_pkg::KIND_SET_FUNC:   func_we = go;
				gpc_pkg::KIND_GET_FUNC:
					res.read_value = func_rd[{cmd.idx[2:0], 2'b00} +: gpc_pkg::FUNC_W];
				gpc_pkg::KIND_WRITE_BIT:  data_we = go;
				gpc_pkg::KIND_READ_BIT:
					res.read_value = {3'b000, data_rd[cmd.idx]};
				gpc_pkg::KIND_SET_PULLUP: pull_we = go;
				default:                  res.invalid = 1'b1;
			endcase
		end
	end

	// stores, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gpc_pkg::FUNC_WORDS; i++) begin
				func_words_q[i] <= '0;
			end
			for (int i = 0; i < gpc_pkg::DATA_WORDS; i++) begin
				data_words_q[i] <= '0;
			end
			for (int i = 0; i < gpc_pkg::PULL_WORDS; i++) begin
				pull_words_q[i] <= '0;
			end
		end else begin
			if (func_we) begin
				func_words_q[fw] <= func_new;
			end
			if (data_we) begin
				data_words_q[cmd.group] <= data_new;
			end
			if (pull_we) begin
				pull_words_q[pw] <= pull_new;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/gpio_pin_config_controller.sv
// gpio_pin_config_controller: top level, front decode, command queue, back stores,
// result queue; depends on gpc_pkg, gpc_front, gpc_queue, gpc_back
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------
//   request  | push / full        | kind, pin_id, value
//   result   | pop / empty        | read_value, invalid
//
// one request is taken per cycle while full is low; its result passes the command queue and
// then the result queue before it is poppable.
// the back executes one command per cycle while a result slot is free, as a read-modify-write
// on flip-flop stores; the stores and queues are cleared by arst_n.
// a stalled result side fills the result queue, then the command queue, then full rises.
`default_nettype none

module gpio_pin_config_controller #(
	parameter int LAST_PIN_B = gpc_pkg::LAST_PIN_B_DEF,
	parameter int LAST_PIN_C = gpc_pkg::LAST_PIN_C_DEF,
	parameter int LAST_PIN_D = gpc_pkg::LAST_PIN_D_DEF,
	parameter int LAST_PIN_E = gpc_pkg::LAST_PIN_E_DEF,
	parameter int LAST_PIN_F = gpc_pkg::LAST_PIN_F_DEF,
	parameter int LAST_PIN_G = gpc_pkg::LAST_PIN_G_DEF,
	parameter int CMD_DEPTH  = gpc_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH  = gpc_pkg::RES_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  kind,
	input  wire logic [11:0] pin_id,
	input  wire logic [7:0]  value,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       read_value,
	output logic             invalid
);

	gpc_pkg::cmd_t front_cmd;
	gpc_pkg::cmd_t back_cmd;
	gpc_pkg::res_t back_res;
	gpc_pkg::res_t out_res;
	logic          cmd_empty;
	logic          cmd_pop;
	logic          res_full;
	logic          res_push;

	// request decode
	gpc_front #(
		.LAST_PIN_B(LAST_PIN_B),
		.LAST_PIN_C(LAST_PIN_C),
		.LAST_PIN_D(LAST_PIN_D),
		.LAST_PIN_E(LAST_PIN_E),
		.LAST_PIN_F(LAST_PIN_F),
		.LAST_PIN_G(LAST_PIN_G)
	) u_front (
		.kind  (kind),
		.pin_id(pin_id),
		.value (value),
		.cmd   (front_cmd)
	);

	// command queue between front and back
	gpc_queue #(
		.WIDTH($bits(gpc_pkg::cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (front_cmd),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (back_cmd),
		.empty (cmd_empty)
	);

	// store access
	gpc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (back_cmd),
		.cmd_valid(!cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (back_res)
	);

	// result queue
	gpc_queue #(
		.WIDTH($bits(gpc_pkg::res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (back_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign read_value = out_res.read_value;
	assign invalid    = out_res.invalid;

`ifndef ASSERT_OFF
	// rejected requests never carry read data
	a_zero_on_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && invalid) |-> (read_value == 4'd0))
		else $error("read_value nonzero on invalid result");

	// back never pushes into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result queue overflow");

	// a result appears only after the back has pushed one
	a_res_from_back: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !res_push) |=> empty)
		else $error("result appeared without a back push");
`endif

endmodule

`default_nettype wire

FILE: sim/gpc_checker.sv
// gpc_checker: follows the request and result transfers of the gpio pin config controller,
// predicts every reply from its own copy of the pin stores and compares them in order
// depends on gpc_pkg
`default_nettype none

module gpc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic [2:0]  kind,
	input  wire logic [11:0] pin_id,
	input  wire logic [7:0]  value,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [3:0]  read_value,
	input  wire logic        invalid,
	output int               mismatches,
	output int               outstanding,
	output int               replies_checked,
	output int               rejects_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// highest pin index that the stores can hold
	localparam int STORE_LAST_PIN  = 23;
	localparam int FUNCS_PER_WORD  = gpc_pkg::WORD_W / gpc_pkg::FUNC_W;
	localparam int PULL_W          = 2;
	localparam int PULLS_PER_WORD  = gpc_pkg::WORD_W / PULL_W;
	localparam int FWORDS_PER_GRP  = gpc_pkg::FUNC_WORDS / gpc_pkg::NUM_GROUPS;
	localparam int PWORDS_PER_GRP  = gpc_pkg::PULL_WORDS / gpc_pkg::NUM_GROUPS;

	// local copy of the pin stores
	logic [gpc_pkg::WORD_W-1:0] func_words [gpc_pkg::FUNC_WORDS];
	logic [gpc_pkg::WORD_W-1:0] level_words[gpc_pkg::DATA_WORDS];
	logic [gpc_pkg::WORD_W-1:0] pull_words [gpc_pkg::PULL_WORDS];

	// replies owed by the block, oldest first
	gpc_pkg::res_t pending_replies[$];
	gpc_pkg::res_t want;

	function automatic int unsigned last_pin(input logic [3:0] grp);
		case (grp)
			gpc_pkg::GROUP_B: return gpc_pkg::LAST_PIN_B_DEF;
			gpc_pkg::GROUP_C: return gpc_pkg::LAST_PIN_C_DEF;
			gpc_pkg::GROUP_D: return gpc_pkg::LAST_PIN_D_DEF;
			gpc_pkg::GROUP_E: return gpc_pkg::LAST_PIN_E_DEF;
			gpc_pkg::GROUP_F: return gpc_pkg::LAST_PIN_F_DEF;
			default: return gpc_pkg::LAST_PIN_G_DEF;
		endcase
	endfunction

	// carry out one pin access on the local stores and return the reply it earns
	function automatic gpc_pkg::res_t apply_pin_request(input logic [2:0] k,
			input logic [11:0] pid, input logic [7:0] val);
		logic [3:0]    grp;
		logic [7:0]    idx;
		int unsigned   fw;
		int unsigned   fsh;
		int unsigned   pw;
		int unsigned   psh;
		gpc_pkg::res_t r;
		grp = pid[11:8];
		idx = pid[7:0];
		r = '0;
		if (k > gpc_pkg::KIND_SET_PULLUP || grp >= gpc_pkg::NUM_GROUPS ||
				idx > STORE_LAST_PIN || idx > last_pin(grp)) begin
			r.invalid = 1'b1;
			return r;
		end
		fw  = grp * FWORDS_PER_GRP + idx / FUNCS_PER_WORD;
		fsh = (idx % FUNCS_PER_WORD) * gpc_pkg::FUNC_W;
		pw  = grp * PWORDS_PER_GRP + idx / PULLS_PER_WORD;
		psh = (idx % PULLS_PER_WORD) * PULL_W;
		case (k)
			gpc_pkg::KIND_SET_FUNC: begin
				if (val >= (1 << gpc_pkg::FUNC_W))
					r.invalid = 1'b1;
				else
					func_words[fw][fsh +: gpc_pkg::FUNC_W] = val[gpc_pkg::FUNC_W-1:0];
			end
			gpc_pkg::KIND_GET_FUNC: begin
				r.read_value = func_words[fw][fsh +: gpc_pkg::FUNC_W];
			end
			gpc_pkg::KIND_WRITE_BIT: begin
				level_words[grp][idx] = (val != 8'd0);
			end
			gpc_pkg::KIND_READ_BIT: begin
				r.read_value = {3'b000, level_words[grp][idx]};
			end
			gpc_pkg::KIND_SET_PULLUP: begin
				pull_words[pw][psh +: PULL_W] = gpc_pkg::PULL_UP;
			end
			default: ;
		endcase
		return r;
	endfunction

	// compare result transfers, then record request transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (func_words[i])
				func_words[i] = '0;
			foreach (level_words[i])
				level_words[i] = '0;
			foreach (pull_words[i])
				pull_words[i] = '0;
			pending_replies.delete();
			outstanding = 0;
			mismatches = 0;
			replies_checked = 0;
			rejects_seen = 0;
		end else begin
			if (pop && !empty) begin
				if (pending_replies.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result transfer, expected none, %s %0d %0b",
						$time, "got read_value/invalid", read_value, invalid);
				end else begin
					want = pending_replies.pop_front();
					if (read_value !== want.read_value) begin
						mismatches++;
						$display("%0t: read_value mismatch, expected %0d, got %0d",
							$time, want.read_value, read_value);
					end
					if (invalid !== want.invalid) begin
						mismatches++;
						$display("%0t: invalid mismatch, expected %0b, got %0b",
							$time, want.invalid, invalid);
					end
					replies_checked++;
					if (want.invalid)
						rejects_seen++;
				end
			end
			if (push && !full)
				pending_replies.push_back(apply_pin_request(kind, pin_id, value));
			outstanding = pending_replies.size();
		end
	end

endmodule

`default_nettype wire

FILE: sim/tb_gpio_pin_config_controller.sv
// tb_gpio_pin_config_controller: drives pin requests into the gpio pin config controller
// with bursty pushes and patterned pops; depends on gpc_pkg, gpc_checker and the hdl/ sources
`default_nettype none

module tb_gpio_pin_config_controller;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 9;
	localparam int RANDOM_REQUESTS = 600;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CYCLE_LIMIT     = 200000;

	// pop patterns of the result side
	typedef enum logic [1:0] {
		RX_STREAM,
		RX_COIN,
		RX_SPARSE,
		RX_WINDOW
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  kind;
	logic [11:0] pin_id;
	logic [7:0]  value;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  read_value;
	logic        invalid;

	int mismatches;
	int outstanding;
	int replies_checked;
	int rejects_seen;
	int requests_sent = 0;
	int cycle_count = 0;

	rx_mode_t   rx_mode = RX_STREAM;
	int         rx_phase_left = 0;
	logic [4:0] rx_tick = '0;

	gpio_pin_config_controller dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.pin_id     (pin_id),
		.value      (value),
		.empty      (empty),
		.pop        (pop),
		.read_value (read_value),
		.invalid    (invalid)
	);

	gpc_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.kind            (kind),
		.pin_id          (pin_id),
		.value           (value),
		.empty           (empty),
		.pop             (pop),
		.read_value      (read_value),
		.invalid         (invalid),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.replies_checked (replies_checked),
		.rejects_seen    (rejects_seen)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still owed", cycle_count, outstanding);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: each pattern holds for a random stretch
	always @(negedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(RX_STREAM, RX_WINDOW));
			rx_phase_left <= $urandom_range(30, 100);
		end else begin
			rx_phase_left <= rx_phase_left - 1;
		end
		case (rx_mode)
			RX_STREAM: pop <= 1'b1;
			RX_COIN:   pop <= 1'($urandom_range(0, 1));
			RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
			default:   pop <= (rx_tick[4:3] == 2'b00);
		endcase
		rx_tick <= rx_tick + 5'd1;
	end

	function automatic logic [11:0] pin_of(input logic [3:0] grp, input logic [7:0] idx);
		return {grp, idx};
	endfunction

	function automatic int unsigned group_last(input logic [3:0] grp);
		case (grp)
			gpc_pkg::GROUP_B: return gpc_pkg::LAST_PIN_B_DEF;
			gpc_pkg::GROUP_C: return gpc_pkg::LAST_PIN_C_DEF;
			gpc_pkg::GROUP_D: return gpc_pkg::LAST_PIN_D_DEF;
			gpc_pkg::GROUP_E: return gpc_pkg::LAST_PIN_E_DEF;
			gpc_pkg::GROUP_F: return gpc_pkg::LAST_PIN_F_DEF;
			default: return gpc_pkg::LAST_PIN_G_DEF;
		endcase
	endfunction

	// hold one request until its transfer
	task automatic send_request(input logic [2:0] k, input logic [11:0] pid,
			input logic [7:0] val);
		@(negedge clk);
		push = 1'b1;
		kind = k;
		pin_id = pid;
		value = val;
		do
			@(posedge clk);
		while (full);
		requests_sent++;
	endtask

	// drop push for some cycles, with junk on the request fields
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		push = 1'b0;
		kind = 3'($urandom);
		pin_id = 12'($urandom);
		value = 8'($urandom);
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	task automatic wait_for_replies();
		pause_sender(1);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// mostly valid pins with random content, some plain noise
	task automatic send_random_request();
		logic [3:0] grp;
		logic [7:0] idx;
		logic [2:0] k;
		logic [7:0] val;
		if ($urandom_range(0, 99) < 15) begin
			send_request(3'($urandom), 12'($urandom), 8'($urandom));
		end else begin
			grp = 4'($urandom_range(gpc_pkg::GROUP_B, gpc_pkg::GROUP_G));
			idx = 8'($urandom_range(0, group_last(grp)));
			k = 3'($urandom_range(gpc_pkg::KIND_SET_FUNC, gpc_pkg::KIND_SET_PULLUP));
			case ($urandom_range(0, 3))
				0:       val = 8'd0;
				1:       val = 8'd1;
				2:       val = 8'($urandom_range(0, 15));
				default: val = 8'($urandom);
			endcase
			send_request(k, pin_of(grp, idx), val);
		end
	endtask

	initial begin
		int sent_random;
		int burst;
		arst_n = 1'b0;
		push = 1'b0;
		kind = '0;
		pin_id = '0;
		value = '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// function field: untouched, full scale, last pin of a group, too-large codes
		send_request(gpc_pkg::KIND_GET_FUNC, pin_of(gpc_pkg::GROUP_B, 8'd0), 8'h00);
		send_request(gpc_pkg::KIND_SET_FUNC, pin_of(gpc_pkg::GROUP_B, 8'd0), 8'd15);
		send_request(gpc_pkg::KIND_GET_FUNC, pin_of(gpc_pkg::GROUP_B, 8'd0), 8'hff);
		send_request(gpc_pkg::KIND_SET_FUNC,
			pin_of(gpc_pkg::GROUP_G, 8'(gpc_pkg::LAST_PIN_G_DEF)), 8'd10);
		send_request(gpc_pkg::KIND_GET_FUNC,
			pin_of(gpc_pkg::GROUP_G, 8'(gpc_pkg::LAST_PIN_G_DEF)), 8'd0);
		send_request(gpc_pkg::KIND_SET_FUNC, pin_of(gpc_pkg::GROUP_B, 8'd0), 8'd16);
		send_request(gpc_pkg::KIND_SET_FUNC, pin_of(gpc_pkg::GROUP_B, 8'd0), 8'hff);
		send_request(gpc_pkg::KIND_GET_FUNC, pin_of(gpc_pkg::GROUP_B, 8'd0), 8'd0);
		// data bit: any nonzero level is high
		send_request(gpc_pkg::KIND_WRITE_BIT,
			pin_of(gpc_pkg::GROUP_D, 8'(gpc_pkg::LAST_PIN_D_DEF)), 8'h80);
		send_request(gpc_pkg::KIND_READ_BIT,
			pin_of(gpc_pkg::GROUP_D, 8'(gpc_pkg::LAST_PIN_D_DEF)), 8'h00);
		send_request(gpc_pkg::KIND_WRITE_BIT,
			pin_of(gpc_pkg::GROUP_D, 8'(gpc_pkg::LAST_PIN_D_DEF)), 8'h00);
		send_request(gpc_pkg::KIND_READ_BIT,
			pin_of(gpc_pkg::GROUP_D, 8'(gpc_pkg::LAST_PIN_D_DEF)), 8'hff);
		send_request(gpc_pkg::KIND_WRITE_BIT,
			pin_of(gpc_pkg::GROUP_C, 8'(gpc_pkg::LAST_PIN_C_DEF)), 8'h01);
		send_request(gpc_pkg::KIND_READ_BIT,
			pin_of(gpc_pkg::GROUP_C, 8'(gpc_pkg::LAST_PIN_C_DEF)), 8'h00);
		// pull-up
		send_request(gpc_pkg::KIND_SET_PULLUP,
			pin_of(gpc_pkg::GROUP_E, 8'(gpc_pkg::LAST_PIN_E_DEF)), 8'hff);
		send_request(gpc_pkg::KIND_SET_PULLUP,
			pin_of(gpc_pkg::GROUP_F, 8'(gpc_pkg::LAST_PIN_F_DEF)), 8'h00);
		// pins past the group end, past the storage limit, and bad groups
		send_request(gpc_pkg::KIND_SET_FUNC,
			pin_of(gpc_pkg::GROUP_B, 8'(gpc_pkg::LAST_PIN_B_DEF + 1)), 8'd3);
		send_request(gpc_pkg::KIND_READ_BIT,
			pin_of(gpc_pkg::GROUP_F, 8'(gpc_pkg::LAST_PIN_F_DEF + 1)), 8'd0);
		send_request(gpc_pkg::KIND_SET_PULLUP, pin_of(gpc_pkg::GROUP_D, 8'd24), 8'd0);
		send_request(gpc_pkg::KIND_GET_FUNC, pin_of(gpc_pkg::GROUP_G + 4'd1, 8'd0), 8'd0);
		send_request(gpc_pkg::KIND_WRITE_BIT, 12'hfff, 8'hff);
		// kinds beyond set pull-up
		for (int k = int'(gpc_pkg::KIND_SET_PULLUP) + 1; k < (1 << 3); k++)
			send_request(3'(k), pin_of(gpc_pkg::GROUP_B, 8'd0), 8'd1);
		wait_for_replies();

		// random bursts with gaps, back-to-back runs and the odd full drain
		sent_random = 0;
		while (sent_random < RANDOM_REQUESTS) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst; i++) begin
				send_random_request();
				sent_random++;
			end
			case ($urandom_range(0, 9))
				0:       wait_for_replies();
				1, 2, 3: ;
				default: pause_sender($urandom_range(1, 8));
			endcase
		end

		wait_for_replies();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		$display("covered %0d requests over all request kinds, %0d replies checked, %0d rejected",
			requests_sent, replies_checked, rejects_seen);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
